// ===== rtl/bmsr_pkg.sv =====
// bmsr_pkg: shared types and constants of the soft-ramp bridge drive
// item structs, direction codes, window sizing and the mean reciprocal
// no dependencies
`default_nettype none

package bmsr_pkg;

  // window sizing
  localparam int unsigned WINDOW_DEPTH = 8;
  localparam int unsigned PTR_W        = (WINDOW_DEPTH > 1) ? $clog2(WINDOW_DEPTH) : 1;
  localparam int unsigned POWER_W      = 7;
  localparam int unsigned DIR_W        = 2;
  localparam int unsigned DUTY_W       = 8;

  // percent limits
  localparam logic [POWER_W-1:0] POWER_MAX  = 7'd100;
  localparam logic [POWER_W-1:0] POWER_ZERO = 7'd0;
  localparam logic [POWER_W-1:0] THR_RESET  = 7'd5;

  // running sum holds up to POWER_MAX * WINDOW_DEPTH
  localparam int unsigned SUM_MAX = 100 * WINDOW_DEPTH;
  localparam int unsigned SUM_W   = $clog2(SUM_MAX + 1);

  // mean = (sum * RECIP) >> DIV_SHIFT, exact for any sum below 2**SUM_W
  localparam int unsigned DIV_SHIFT = SUM_W + $clog2(WINDOW_DEPTH);
  localparam int unsigned RECIP_W   = DIV_SHIFT + 1;
  localparam int unsigned RECIP_INT = ((1 << DIV_SHIFT) + WINDOW_DEPTH - 1) / WINDOW_DEPTH;
  localparam logic [RECIP_W-1:0] RECIP = RECIP_W'(RECIP_INT);

  // direction codes
  localparam logic [DIR_W-1:0] DIR_OFF = 2'd0;
  localparam logic [DIR_W-1:0] DIR_CW  = 2'd1;
  localparam logic [DIR_W-1:0] DIR_CCW = 2'd2;
  localparam logic [DIR_W-1:0] DIR_BAD = 2'd3;

  // one control tick
  typedef struct packed {
    logic [POWER_W-1:0] requested_power;
    logic [DIR_W-1:0]   requested_direction;
  } in_item_t;

  // one bridge command
  typedef struct packed {
    logic [POWER_W-1:0] filtered_power;
    logic [DIR_W-1:0]   active_direction;
    logic [DUTY_W-1:0]  pwm_duty;
    logic               high_side_one;
    logic               high_side_two;
    logic               low_one_pwm;
    logic               low_one_level;
    logic               low_two_pwm;
    logic               low_two_level;
  } out_item_t;

  // push into the averaging window
  typedef struct packed {
    logic               en;
    logic [POWER_W-1:0] value;
  } win_push_t;

  // window status toward the control logic
  typedef struct packed {
    logic [POWER_W-1:0] power;       // mean after the last push
    logic [POWER_W-1:0] power_next;  // mean including the current push
  } win_stat_t;

endpackage

`default_nettype wire

// ===== rtl/brushed_motor_soft_ramp_bridge_drive_core.sv =====
// brushed_motor_soft_ramp_bridge_drive_core: top level of the soft-ramp h-bridge drive
// depends on bmsr_pkg, bmsr_window, bmsr_outbuf (and bmsr_ram below it)
//
// Usage:
//  - input channel (in_valid_i / in_stall_o / in_data_i) carries one control tick:
//    requested power in percent and requested direction
//  - output channel (out_valid_o / out_stall_i / out_data_o) returns exactly one
//    bridge command per tick: filtered power, active direction, pwm duty and switches
//  - cfg_we_i / cfg_wdata_i write the reverse threshold; write only while idle
//  - result: registered in the output buffer, valid in the cycle after its input transaction if the output is free
//  - throughput: one tick per cycle while in_stall_o is low; the history ram is prefetched
//    one slot ahead of the write pointer, so its read and write share every cycle
//  - reset: history reads as zero through per-slot valid bits (no clearing pass),
//    direction off, latches clear, threshold 5
//  - receiver stall: a two-entry output buffer keeps accepting until both entries
//    hold commands, then in_stall_o rises until the receiver takes one
`default_nettype none

module brushed_motor_soft_ramp_bridge_drive_core (
  input  wire                  clk_i,
  input  wire                  rst_ni,
  input  wire                  in_valid_i,
  output logic                 in_stall_o,
  input  bmsr_pkg::in_item_t   in_data_i,
  output logic                 out_valid_o,
  input  wire                  out_stall_i,
  output bmsr_pkg::out_item_t  out_data_o,
  input  wire                  cfg_we_i,
  input  wire [6:0]            cfg_wdata_i
);

  import bmsr_pkg::*;

  logic               in_acc;
  logic [POWER_W-1:0] thr_q;
  logic [DIR_W-1:0]   dir_q, dir_d;
  logic               lat1_q, lat1_d, lat2_q, lat2_d;
  logic [POWER_W-1:0] req_pow;
  logic [DIR_W-1:0]   req_dir;
  win_push_t          push;
  win_stat_t          stat;
  out_item_t          res;
  logic               hs1, hs2, pwm1, pwm2;
  logic [POWER_W-1:0] pwr;

  assign in_acc = in_valid_i && !in_stall_o;

  // sanitize request: saturate power, unused direction code means off
  assign req_pow = (in_data_i.requested_power > POWER_MAX) ? POWER_MAX
                                                            : in_data_i.requested_power;
  assign req_dir = (in_data_i.requested_direction == DIR_BAD) ? DIR_OFF
                                                              : in_data_i.requested_direction;

  // direction change pushes zero; switch only below threshold
  always_comb begin
    push.en    = in_acc;
    push.value = req_pow;
    dir_d      = dir_q;
    if (req_dir != dir_q) begin
      push.value = POWER_ZERO;
      if (stat.power < thr_q) begin
        dir_d = req_dir;
      end
    end
  end

  bmsr_window u_window (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .push_i (push),
    .stat_o (stat)
  );

  assign pwr = stat.power_next;

  // bridge drive
  always_comb begin
    hs1    = 1'b0;
    hs2    = 1'b0;
    pwm1   = 1'b0;
    pwm2   = 1'b0;
    lat1_d = lat1_q;
    lat2_d = lat2_q;
    case (dir_d)
      DIR_CW: begin
        hs1    = 1'b1;
        lat1_d = 1'b0;
        if (pwr == POWER_MAX) begin
          lat2_d = 1'b1;
        end else begin
          pwm2 = 1'b1;
        end
      end
      DIR_CCW: begin
        hs2    = 1'b1;
        lat2_d = 1'b0;
        if (pwr == POWER_MAX) begin
          lat1_d = 1'b1;
        end else begin
          pwm1 = 1'b1;
        end
      end
      default: begin
      end
    endcase
    if (dir_d == DIR_OFF || pwr == POWER_ZERO) begin
      hs1  = 1'b0;
      hs2  = 1'b0;
      pwm1 = 1'b0;
      pwm2 = 1'b0;
    end
  end

  // result assembly
  always_comb begin
    res.filtered_power   = pwr;
    res.active_direction = dir_d;
    res.pwm_duty         = {pwr, 1'b0};
    res.high_side_one    = hs1;
    res.high_side_two    = hs2;
    res.low_one_pwm      = pwm1;
    res.low_one_level    = lat1_d;
    res.low_two_pwm      = pwm2;
    res.low_two_level    = lat2_d;
  end

  // control state and threshold register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      thr_q  <= THR_RESET;
      dir_q  <= DIR_OFF;
      lat1_q <= 1'b0;
      lat2_q <= 1'b0;
    end else begin
      if (cfg_we_i) begin
        thr_q <= cfg_wdata_i;
      end
      if (in_acc) begin
        dir_q  <= dir_d;
        lat1_q <= lat1_d;
        lat2_q <= lat2_d;
      end
    end
  end

  bmsr_outbuf u_outbuf (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_data_i   (res),
    .in_stall_o  (in_stall_o),
    .out_valid_o (out_valid_o),
    .out_stall_i (out_stall_i),
    .out_data_o  (out_data_o)
  );

endmodule

`default_nettype wire

// ===== rtl/bmsr_ram.sv =====
// bmsr_ram: generic single-write, single-read ram with registered read data
// depends on nothing
`default_nettype none

module bmsr_ram #(
  parameter int unsigned WIDTH = 8,
  parameter int unsigned DEPTH = 8
) (
  input  wire                                          clk_i,
  input  wire                                          we_i,
  input  wire [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] waddr_i,
  input  wire [WIDTH-1:0]                              wdata_i,
  input  wire [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] raddr_i,
  output logic [WIDTH-1:0]                             rdata_o
);

  logic [WIDTH-1:0] mem [DEPTH];

  // write port
  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem[waddr_i] <= wdata_i;
    end
  end

  // registered read port
  always_ff @(posedge clk_i) begin
    rdata_o <= mem[raddr_i];
  end

endmodule

`default_nettype wire

// ===== rtl/bmsr_window.sv =====
// bmsr_window: power history ram, write pointer, running sum and window mean
// depends on bmsr_pkg and bmsr_ram
`default_nettype none

module bmsr_window (
  input  wire                  clk_i,
  input  wire                  rst_ni,
  input  bmsr_pkg::win_push_t  push_i,
  output bmsr_pkg::win_stat_t  stat_o
);

  import bmsr_pkg::*;

  logic [PTR_W-1:0]        wp_q, wp_d, wp_next, rd_addr;
  logic [WINDOW_DEPTH-1:0] vld_q, vld_d;
  logic                    vld_rd_q, fwd_q;
  logic [POWER_W-1:0]      fwd_val_q;
  logic [POWER_W-1:0]      rdata, old_val;
  logic [SUM_W-1:0]        sum_q, sum_d;
  logic [POWER_W-1:0]      power_q, power_d;
  logic [SUM_W+RECIP_W-1:0] prod;

  // history memory, one entry per tick slot
  bmsr_ram #(
    .WIDTH (POWER_W),
    .DEPTH (WINDOW_DEPTH)
  ) u_hist_ram (
    .clk_i   (clk_i),
    .we_i    (push_i.en),
    .waddr_i (wp_q),
    .wdata_i (push_i.value),
    .raddr_i (rd_addr),
    .rdata_o (rdata)
  );

  // pointer wrap and prefetch of the slot that the next push overwrites
  assign wp_next = (wp_q == PTR_W'(WINDOW_DEPTH - 1)) ? '0 : wp_q + PTR_W'(1);
  assign wp_d    = push_i.en ? wp_next : wp_q;
  assign rd_addr = wp_d;

  // entry leaving the window: forwarded write, stored value, or reset zero
  always_comb begin
    if (fwd_q) begin
      old_val = fwd_val_q;
    end else if (vld_rd_q) begin
      old_val = rdata;
    end else begin
      old_val = POWER_ZERO;
    end
  end

  // valid bits stand in for the all-zero reset of the history
  always_comb begin
    vld_d = vld_q;
    if (push_i.en) begin
      vld_d[wp_q] = 1'b1;
    end
  end

  // running sum and mean by reciprocal multiply
  assign sum_d   = push_i.en ? (sum_q - SUM_W'(old_val) + SUM_W'(push_i.value)) : sum_q;
  assign prod    = {{RECIP_W{1'b0}}, sum_d} * {{SUM_W{1'b0}}, RECIP};
  assign power_d = prod[DIV_SHIFT +: POWER_W];

  assign stat_o.power      = power_q;
  assign stat_o.power_next = power_d;

  // window state
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wp_q     <= '0;
      vld_q    <= '0;
      vld_rd_q <= 1'b0;
      fwd_q    <= 1'b0;
      sum_q    <= '0;
      power_q  <= POWER_ZERO;
    end else begin
      wp_q     <= wp_d;
      vld_q    <= vld_d;
      vld_rd_q <= vld_q[rd_addr];
      fwd_q    <= push_i.en && (rd_addr == wp_q);
      sum_q    <= sum_d;
      power_q  <= power_d;
    end
  end

  // forwarded value for a read of the slot being written
  always_ff @(posedge clk_i) begin
    fwd_val_q <= push_i.value;
  end

  // a forward only follows a push
  a_fwd_after_push: assert property (@(posedge clk_i) disable iff (!rst_ni)
    fwd_q |-> $past(push_i.en))
    else $error("forward flag without a preceding push");

  // a pushed slot is marked valid
  a_slot_valid: assert property (@(posedge clk_i) disable iff (!rst_ni)
    push_i.en |=> vld_q[$past(wp_q)])
    else $error("pushed slot not marked valid");

  // mean stays within percent range
  a_power_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    power_q <= POWER_MAX)
    else $error("window mean above full power");

  // pointer moves only on a push
  a_ptr_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !push_i.en |=> $stable(wp_q))
    else $error("write pointer moved without a push");

endmodule

`default_nettype wire

// ===== rtl/bmsr_outbuf.sv =====
// bmsr_outbuf: two-entry output register with skid stage for bridge commands
// depends on bmsr_pkg
`default_nettype none

module bmsr_outbuf (
  input  wire                  clk_i,
  input  wire                  rst_ni,
  input  wire                  in_valid_i,
  input  bmsr_pkg::out_item_t  in_data_i,
  output logic                 in_stall_o,
  output logic                 out_valid_o,
  input  wire                  out_stall_i,
  output bmsr_pkg::out_item_t  out_data_o
);

  import bmsr_pkg::*;

  logic      out_vld_q, out_vld_d;
  logic      skid_vld_q, skid_vld_d;
  out_item_t out_q, out_d;
  out_item_t skid_q, skid_d;
  logic      in_acc, out_take;

  // stall only once the skid entry is occupied
  assign in_stall_o = skid_vld_q;
  assign in_acc     = in_valid_i && !skid_vld_q;
  assign out_take   = out_vld_q && !out_stall_i;

  // fill and drain
  always_comb begin
    out_vld_d  = out_vld_q;
    skid_vld_d = skid_vld_q;
    out_d      = out_q;
    skid_d     = skid_q;
    if (skid_vld_q) begin
      if (out_take) begin
        out_d      = skid_q;
        skid_vld_d = 1'b0;
      end
    end else if (!out_vld_q || out_take) begin
      out_vld_d = in_acc;
      out_d     = in_data_i;
    end else if (in_acc) begin
      skid_vld_d = 1'b1;
      skid_d     = in_data_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_vld_q  <= 1'b0;
      skid_vld_q <= 1'b0;
    end else begin
      out_vld_q  <= out_vld_d;
      skid_vld_q <= skid_vld_d;
    end
  end

  always_ff @(posedge clk_i) begin
    out_q  <= out_d;
    skid_q <= skid_d;
  end

  assign out_valid_o = out_vld_q;
  assign out_data_o  = out_q;

  // skid entry never holds data ahead of an empty output
  a_skid_behind_out: assert property (@(posedge clk_i) disable iff (!rst_ni)
    skid_vld_q |-> out_vld_q)
    else $error("skid entry occupied while output empty");

  // skid fills only when the output was held
  a_skid_fill: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(skid_vld_q) |-> $past(out_vld_q && out_stall_i))
    else $error("skid filled while output free");

  // a held skid entry moves to the output when taken
  a_skid_drain: assert property (@(posedge clk_i) disable iff (!rst_ni)
    skid_vld_q && out_take |=> out_vld_q && !skid_vld_q)
    else $error("skid entry not drained on output transaction");

endmodule

`default_nettype wire
